// ===== rtl/lrucs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrucs_pkg
// Shared constants and types for the cache set lookup and fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrucs_pkg;

	// Set geometry.
	localparam int WAYS     = 4;
	localparam int TAG_BITS = 20;

	// Widths of the request and response fields.
	localparam int TAG_W = 20;
	localparam int WAY_W = 2;

	// Bits needed to number a way, and to hold a recency rank one past the last.
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_BITS = WAY_BITS + 1;

	// Controller states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lrucs_if.sv =====
// ----------------------------------------------------------------------------
// lrucs_req_if / lrucs_rsp_if
// Valid/ready channels for cache set requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrucs_req_if
	import lrucs_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [TAG_W-1:0] tag;
	logic             is_write;

	modport source (output valid, output tag, output is_write, input ready);
	modport sink   (input valid, input tag, input is_write, output ready);
endinterface

interface lrucs_rsp_if
	import lrucs_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic             hit;
	logic [WAY_W-1:0] way;
	logic             write_back;
	logic [TAG_W-1:0] victim_tag;
	logic             evicted;

	modport source (output valid, output hit, output way, output write_back,
		output victim_tag, output evicted, input ready);
	modport sink   (input valid, input hit, input way, input write_back,
		input victim_tag, input evicted, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrucs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrucs_ctrl
// Controller: takes one request, runs the lookup and holds the response
// until it has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lrucs_ctrl
	import lrucs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// A new request is taken when idle and the response register is free or emptying.
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.capture = accept;
	assign cmd.execute = (state_q == ST_EXEC);

	// State and response-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lrucs_dp.sv =====
// ----------------------------------------------------------------------------
// lrucs_dp
// Datapath: line tags, valid and dirty bits, per-way recency ranks, the
// parallel tag compare, victim choice and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrucs_dp
	import lrucs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [TAG_W-1:0] in_tag,
	input  wire logic             in_is_write,
	output logic                  hit,
	output logic [WAY_W-1:0]      way,
	output logic                  write_back,
	output logic [TAG_W-1:0]      victim_tag,
	output logic                  evicted
);

	// Captured request.
	logic [TAG_BITS-1:0] req_tag_q;
	logic                req_wr_q;

	// Line state.
	logic [TAG_BITS-1:0] tags_q  [WAYS];
	logic [WAYS-1:0]     valid_q;
	logic [WAYS-1:0]     dirty_q;
	logic [WAY_BITS-1:0] rank_q  [WAYS];

	// Response register.
	logic                hit_q;
	logic [WAY_W-1:0]    way_q;
	logic                write_back_q;
	logic [TAG_W-1:0]    victim_tag_q;
	logic                evicted_q;

	// Lookup results.
	logic [WAYS-1:0]      match;
	logic                 any_hit;
	logic                 any_free;
	logic [WAY_BITS-1:0]  hit_idx;
	logic [WAY_BITS-1:0]  free_idx;
	logic [WAY_BITS-1:0]  lru_idx;
	logic [WAY_BITS-1:0]  slot;
	logic                 full_evict;
	logic [RANK_BITS-1:0] slot_rank;

	assign hit        = hit_q;
	assign way        = way_q;
	assign write_back = write_back_q;
	assign victim_tag = victim_tag_q;
	assign evicted    = evicted_q;

	// Request capture; the tag is cut to the stored width.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_tag_q <= TAG_BITS'(in_tag);
			req_wr_q  <= in_is_write;
		end
	end

	// Parallel compare, lowest free way and least recently used way.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		lru_idx  = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			match[j] = valid_q[j] && (tags_q[j] == req_tag_q);
			if (match[j]) begin
				hit_idx = WAY_BITS'(j);
			end
			if (!valid_q[j]) begin
				free_idx = WAY_BITS'(j);
			end
			if (rank_q[j] == WAY_BITS'(WAYS - 1)) begin
				lru_idx = WAY_BITS'(j);
			end
		end
		any_hit    = |match;
		any_free   = ~&valid_q;
		full_evict = !any_hit && !any_free;
		if (any_hit) begin
			slot = hit_idx;
		end else if (any_free) begin
			slot = free_idx;
		end else begin
			slot = lru_idx;
		end
		// A way not yet in the order counts as ranked behind every valid way.
		slot_rank = valid_q[slot] ? RANK_BITS'(rank_q[slot]) : RANK_BITS'(WAYS);
	end

	// Valid, dirty and recency updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int j = 0; j < WAYS; j++) begin
				rank_q[j] <= '0;
			end
		end else if (cmd.execute) begin
			valid_q[slot] <= 1'b1;
			if (any_hit) begin
				dirty_q[slot] <= dirty_q[slot] | req_wr_q;
			end else begin
				dirty_q[slot] <= req_wr_q;
			end
			for (int j = 0; j < WAYS; j++) begin
				if (WAY_BITS'(j) == slot) begin
					rank_q[j] <= '0;
				end else if (valid_q[j] && (RANK_BITS'(rank_q[j]) < slot_rank)) begin
					rank_q[j] <= rank_q[j] + 1'b1;
				end
			end
		end
	end

	// Tag store and response register.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (!any_hit) begin
				tags_q[slot] <= req_tag_q;
			end
			hit_q        <= any_hit;
			way_q        <= WAY_W'(slot);
			evicted_q    <= full_evict;
			write_back_q <= full_evict && dirty_q[slot];
			victim_tag_q <= full_evict ? TAG_W'(tags_q[slot]) : '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lru_cache_set_lookup_fill.sv =====
// ----------------------------------------------------------------------------
// lru_cache_set_lookup_fill
// One set of a set-associative cache with least-recently-used replacement.
//
// Requests arrive on req (tag, is_write); one response per request leaves
// on rsp (hit, way, write_back, victim_tag, evicted). Both channels use a
// valid/ready handshake and move a request on an edge where both are high.
// A request is compared against all ways at once in the cycle after it is
// taken, and its response is valid from the following cycle. The
// capture-then-execute sequence of the controller takes no new request
// while a lookup is in progress.
// The response sits in an output register; when the receiver stalls it is
// held there and no new request is taken before the edge at which it is
// collected.
// An asynchronous reset marks every way invalid and clean and empties the
// recency order; the tags themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_set_lookup_fill
	import lrucs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lrucs_req_if.sink   req,
	lrucs_rsp_if.source rsp
);

	cmd_t cmd;

	// Sequencing of each request.
	lrucs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Line state, lookup and response register.
	lrucs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_tag      (req.tag),
		.in_is_write (req.is_write),
		.hit         (rsp.hit),
		.way         (rsp.way),
		.write_back  (rsp.write_back),
		.victim_tag  (rsp.victim_tag),
		.evicted     (rsp.evicted)
	);

	// A taken request blocks the next one for the lookup cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken during lookup cycle");

	// A response is valid once the lookup after a taken request has filled the response register.
	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> ##1 rsp.valid)
		else $error("response missing after lookup");

	// A hit never evicts and a write-back needs an eviction.
	a_evict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (!(rsp.hit && rsp.evicted) && (!rsp.write_back || rsp.evicted)))
		else $error("inconsistent eviction flags");

	// A new request is only taken when the pending response leaves.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready && rsp.valid |-> rsp.ready)
		else $error("request taken over an unread response");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for one four-way cache set with LRU replacement.
// A short table of hand-picked accesses walks the set through fills, hits,
// clean and dirty evictions and the extreme tags. Random accesses follow,
// drawn mostly from small tag pools so that hits and evictions stay common.
// Every response is checked field by field against the given table result or a
// behavioural copy of the set, under four patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import lrucs_pkg::*;
	;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 8;

	// One response as the block reports it.
	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
		logic             write_back;
		logic [TAG_W-1:0] victim_tag;
		logic             evicted;
	} access_result_t;

	// One row of the directed table; the response is given only where it is obvious.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             is_write;
		logic             known;
		access_result_t   result;
	} access_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lrucs_req_if req_ch ();
	lrucs_rsp_if rsp_ch ();

	lru_cache_set_lookup_fill DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the set.
	logic [TAG_W-1:0] shadow_tags [WAYS];
	logic             shadow_valid [WAYS];
	logic             shadow_dirty [WAYS];
	int unsigned      use_order [WAYS];
	int unsigned      use_count;

	access_result_t pending_results [$];
	access_row_t    directed_rows [$];
	int             mismatches = 0;
	int             sender_idle_pct = 0;
	int             rsp_stall_pct = 0;
	longint         cycle_count = 0;

	// Clock and the single reset at the start of the run.
	always #1 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Move way w to the most recently used position.
	function automatic void touch_way(input int unsigned w);
		int unsigned pos;
		int unsigned i;
		pos = use_count;
		for (i = 0; i < use_count; i++) begin
			if (use_order[i] == w && pos == use_count)
				pos = i;
		end
		if (pos >= use_count) begin
			if (use_count < WAYS)
				use_count++;
			pos = use_count - 1;
		end
		while (pos > 0) begin
			use_order[pos] = use_order[pos - 1];
			pos--;
		end
		use_order[0] = w;
	endfunction

	// Work out the response to one access and update the shadow set.
	function automatic access_result_t predict_access(input logic [TAG_W-1:0] t,
			input logic wr);
		access_result_t r;
		int unsigned    slot;
		int unsigned    w;
		bit             found;
		r = '0;
		found = 1'b0;
		slot = WAYS;
		for (w = 0; w < WAYS; w++) begin
			if (!found && shadow_valid[w] && shadow_tags[w] == t) begin
				found = 1'b1;
				slot = w;
			end
		end
		if (found) begin
			touch_way(slot);
			if (wr)
				shadow_dirty[slot] = 1'b1;
			r.hit = 1'b1;
			r.way = WAY_W'(slot);
			return r;
		end
		for (w = 0; w < WAYS; w++) begin
			if (slot == WAYS && !shadow_valid[w])
				slot = w;
		end
		// A full set gives up its least recently used way.
		if (slot == WAYS) begin
			slot = (use_count > 0) ? use_order[use_count - 1] : 0;
			r.evicted = 1'b1;
			r.write_back = shadow_dirty[slot];
			r.victim_tag = shadow_tags[slot];
		end
		shadow_valid[slot] = 1'b1;
		shadow_tags[slot] = t;
		shadow_dirty[slot] = wr;
		touch_way(slot);
		r.way = WAY_W'(slot);
		return r;
	endfunction

	function automatic access_row_t access_row(input logic [TAG_W-1:0] t, input logic wr,
			input logic known, input logic hit, input int unsigned way, input logic wb,
			input logic [TAG_W-1:0] vt, input logic ev);
		access_row_t row;
		row.tag = t;
		row.is_write = wr;
		row.known = known;
		row.result = '{hit: hit, way: WAY_W'(way), write_back: wb, victim_tag: vt,
			evicted: ev};
		return row;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input logic [TAG_W-1:0] t, input logic wr,
			input logic known, input logic hit, input int unsigned way, input logic wb,
			input logic [TAG_W-1:0] vt, input logic ev);
		directed_rows = {directed_rows, access_row(t, wr, known, hit, way, wb, vt, ev)};
	endfunction

	// Present one request, wait for it to be taken and record its response.
	task automatic send_access(input logic [TAG_W-1:0] t, input logic wr,
			input logic known, input access_result_t given);
		access_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.tag <= TAG_W'($urandom());
			req_ch.is_write <= 1'(~$urandom_range(1));
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.tag <= t;
		req_ch.is_write <= wr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = predict_access(t, wr);
		pending_results = {pending_results, (known ? given : predicted)};
	endtask

	// Random accesses, mostly within a small pool of tags that is renewed now and then.
	task automatic send_random(input int count);
		logic [TAG_W-1:0] pool [8];
		int               pool_size;
		int               n;
		int               k;
		logic [TAG_W-1:0] t;
		pool_size = 1;
		for (n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				pool_size = $urandom_range(2, 8);
				for (k = 0; k < 8; k++) begin
					case ($urandom_range(9))
						0: pool[k] = '0;
						1: pool[k] = '1;
						default: pool[k] = TAG_W'($urandom());
					endcase
				end
			end
			if ($urandom_range(99) < 85)
				t = pool[$urandom_range(pool_size - 1)];
			else
				t = TAG_W'($urandom());
			send_access(t, 1'($urandom_range(1)), 1'b0, '0);
		end
	endtask

	// Compare one response with the oldest expectation.
	task automatic check_response(input access_result_t want, input access_result_t got);
		if (got.hit !== want.hit) begin
			$display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
			mismatches++;
		end
		if (got.way !== want.way) begin
			$display("%0t: way expected %0d actual %0d", $time, want.way, got.way);
			mismatches++;
		end
		if (got.write_back !== want.write_back) begin
			$display("%0t: write_back expected %0d actual %0d", $time, want.write_back,
				got.write_back);
			mismatches++;
		end
		if (got.victim_tag !== want.victim_tag) begin
			$display("%0t: victim_tag expected %h actual %h", $time, want.victim_tag,
				got.victim_tag);
			mismatches++;
		end
		if (got.evicted !== want.evicted) begin
			$display("%0t: evicted expected %0d actual %0d", $time, want.evicted,
				got.evicted);
			mismatches++;
		end
	endtask

	// Response side: collect on the handshake, then choose the next ready.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: response with none outstanding, actual hit %0d way %0d",
						$time, rsp_ch.hit, rsp_ch.way);
					mismatches++;
				end else begin
					check_response(pending_results.pop_front(),
						'{hit: rsp_ch.hit, way: rsp_ch.way, write_back: rsp_ch.write_back,
						victim_tag: rsp_ch.victim_tag, evicted: rsp_ch.evicted});
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Request side and run control.
	initial begin
		req_ch.valid = 1'b0;
		req_ch.tag = '0;
		req_ch.is_write = 1'b0;
		use_count = 0;
		for (int i = 0; i < WAYS; i++) begin
			shadow_tags[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_dirty[i] = 1'b0;
			use_order[i] = 0;
		end

		// Fill an empty set, hit, then evict dirty and clean lines, extremes included.
		add_row(20'h00000, 1'b0, 1'b1, 0, 0, 0, 20'h0, 0);
		add_row(20'hFFFFF, 1'b1, 1'b1, 0, 1, 0, 20'h0, 0);
		add_row(20'h00000, 1'b1, 1'b1, 1, 0, 0, 20'h0, 0);
		add_row(20'h55555, 1'b0, 1'b1, 0, 2, 0, 20'h0, 0);
		add_row(20'hAAAAA, 1'b1, 1'b1, 0, 3, 0, 20'h0, 0);
		add_row(20'h12345, 1'b0, 1'b1, 0, 1, 1, 20'hFFFFF, 1);
		add_row(20'h00001, 1'b0, 1'b1, 0, 0, 1, 20'h00000, 1);
		add_row(20'h67890, 1'b1, 1'b1, 0, 2, 0, 20'h55555, 1);
		add_row(20'hAAAAA, 1'b0, 1'b1, 1, 3, 0, 20'h0, 0);
		add_row(20'h12345, 1'b1, 1'b1, 1, 1, 0, 20'h0, 0);
		add_row(20'hFFFFF, 1'b0, 1'b1, 0, 0, 0, 20'h00001, 1);
		add_row(20'hFFFFF, 1'b1, 1'b0, 0, 0, 0, 20'h0, 0);
		add_row(20'h80000, 1'b1, 1'b0, 0, 0, 0, 20'h0, 0);
		add_row(20'h7FFFF, 1'b0, 1'b0, 0, 0, 0, 20'h0, 0);
		add_row(20'h00000, 1'b0, 1'b0, 0, 0, 0, 20'h0, 0);
		add_row(20'h80000, 1'b0, 1'b0, 0, 0, 0, 20'h0, 0);
		add_row(20'h00001, 1'b1, 1'b0, 0, 0, 0, 20'h0, 0);
		add_row(20'hFFFFE, 1'b1, 1'b0, 0, 0, 0, 20'h0, 0);

		wait (arst_n === 1'b1);
		@(posedge clk);

		// Back-to-back traffic first.
		sender_idle_pct = 0;
		rsp_stall_pct = 0;
		foreach (directed_rows[i])
			send_access(directed_rows[i].tag, directed_rows[i].is_write,
				directed_rows[i].known, directed_rows[i].result);
		send_random(360);

		// A mostly idle sender.
		sender_idle_pct = 78;
		send_random(380);

		// A mostly stalling receiver.
		sender_idle_pct = 0;
		rsp_stall_pct = 78;
		send_random(380);

		// Light idling on both sides.
		sender_idle_pct = 8;
		rsp_stall_pct = 8;
		send_random(380);

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
